@@ rtl/wcq_pkg.sv @@
package wcq_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic REG_MAX_BYTES = 1'b0;
    localparam logic REG_CACHE_EN = 1'b1;

    localparam int KEY_W = 131;
    localparam int SUM_W = 48;
    localparam logic [35:0] BUDGET_RESET = 36'd268435456;
    localparam logic [35:0] M36 = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [2:0]  level;
        logic [15:0] handle;
        logic [7:0]  preset;
        logic [31:0] nbytes;
    } wcq_entry_t;

    // Command broadcast to every cell in a cycle
    typedef struct packed {
        logic shift;     // advance toward the head (cell i takes cell i+1)
        logic load;      // cell at load_idx takes the new entry
        logic update;    // matched cell takes handle, preset, size
    } wcq_ctl_t;

endpackage

@@ rtl/write_coalescing_queue_core.sv @@
// Lookup, drain and flush pass through EXEC and DONE from request to result.
// A write, if enabled, also passes through TRIM to drop entries over budget.
// One request at a time: a new request waits until the last result is taken.
// Entries shift one cell per cycle toward the head while the chain shifts.
// Reset (rst_n, asynchronous, active low) empties the queue; no clearing pass.
module write_coalescing_queue_core
    import wcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [35:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    input  logic [2:0]  level,
    input  logic [15:0] entry_handle,
    input  logic [7:0]  preset,
    input  logic [7:0]  min_quality,
    input  logic [31:0] entry_bytes,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        start_drain,
    output logic [4:0]  dropped_count,
    output logic        hit,
    output logic        busy_res,
    output logic        out_valid,
    output logic [63:0] out_key_hi,
    output logic [63:0] out_key_lo,
    output logic [2:0]  out_level,
    output logic [15:0] out_handle,
    output logic [7:0]  out_preset,
    output logic [31:0] out_bytes,
    output logic [35:0] pending_total
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_TRIM = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0]      state_reg, state_next;
    logic [35:0]     budget_reg;
    logic            enable_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [SUM_W-1:0] pending_reg, pending_next;
    logic            draining_reg, draining_next;
    logic            fbusy_reg, fbusy_next;
    logic [KEY_W-1:0] fkey_reg, fkey_next;
    logic [31:0]     drops_reg, drops_next;
    logic [47:0]     dbytes_reg, dbytes_next;
    logic [4:0]      ndrop_reg, ndrop_next;

    logic [1:0]      rq_mode_reg;
    wcq_entry_t      rq_reg;
    logic [7:0]      rq_minp_reg;

    logic            res_valid_reg, res_valid_next;
    logic            sd_reg, sd_next, hit_reg, hit_next, busy_reg, busy_next;
    logic            ov_reg, ov_next;
    wcq_entry_t      oe_reg, oe_next;

    wcq_ctl_t        ctl;
    wcq_entry_t      cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] eq;
    logic [QUEUE_DEPTH-1:0] live;
    logic [QUEUE_DEPTH-1:0] mvec;
    logic [QUEUE_DEPTH-1:0] load_vec;
    logic            found;
    wcq_entry_t      found_e;
    logic [CW-1:0]   load_idx;

    // Hold off a new request while busy or while a result still waits
    assign in_stall = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);

    // Chain of cells: cell 0 is the head, shift moves everything down one
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            wcq_entry_t nb;
            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign nb = cells[g];
            end
            else
            begin : g_mid
                assign nb = cells[g+1];
            end
            assign live[g] = (CW'(g) < count_reg);
            assign mvec[g] = eq[g] && live[g];
            assign load_vec[g] = ctl.load && (CW'(g) == load_idx);
            wcq_cell u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .load_here    (load_vec[g]),
                .is_match_upd (mvec[g]),
                .new_entry    (rq_reg),
                .neighbor     (nb),
                .cmp_level    (rq_reg.level),
                .cmp_hi       (rq_reg.key_hi),
                .cmp_lo       (rq_reg.key_lo),
                .entry        (cells[g]),
                .key_eq       (eq[g])
            );
        end
    endgenerate

    // Pick the matching cell; keys are unique among live cells
    always_comb
    begin
        found = |mvec;
        found_e = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (mvec[i])
            begin
                found_e = found_e | cells[i];
            end
        end
    end

    // Sequence one request
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pending_next = pending_reg;
        draining_next = draining_reg;
        fbusy_next = fbusy_reg;
        fkey_next = fkey_reg;
        drops_next = drops_reg;
        dbytes_next = dbytes_reg;
        ndrop_next = ndrop_reg;
        res_valid_next = res_valid_reg;
        sd_next = sd_reg;
        hit_next = hit_reg;
        busy_next = busy_reg;
        ov_next = ov_reg;
        oe_next = oe_reg;
        ctl = '0;
        load_idx = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (res_valid_reg && !res_stall)
                begin
                    res_valid_next = 1'b0;
                end
                if (in_valid && !in_stall)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                sd_next = 1'b0;
                hit_next = 1'b0;
                busy_next = 1'b0;
                ov_next = 1'b0;
                oe_next = '0;
                ndrop_next = '0;
                state_next = ST_DONE;
                unique case (rq_mode_reg)
                    MODE_WRITE:
                    begin
                        if (enable_reg)
                        begin
                            state_next = ST_TRIM;
                            if (found)
                            begin
                                ctl.update = 1'b1;
                                pending_next = pending_reg - SUM_W'(found_e.nbytes)
                                    + SUM_W'(rq_reg.nbytes);
                            end
                            else
                            begin
                                if (count_reg == CW'(QUEUE_DEPTH))
                                begin
                                    // Drop head, then append at the tail cell
                                    ctl.shift = 1'b1;
                                    load_idx = CW'(QUEUE_DEPTH - 1);
                                    ndrop_next = 5'd1;
                                    drops_next = drops_reg + 32'd1;
                                    dbytes_next = dbytes_reg + 48'(cells[0].nbytes);
                                    pending_next = pending_reg - SUM_W'(cells[0].nbytes)
                                        + SUM_W'(rq_reg.nbytes);
                                end
                                else
                                begin
                                    count_next = count_reg + CW'(1);
                                    pending_next = pending_reg + SUM_W'(rq_reg.nbytes);
                                end
                                ctl.load = 1'b1;
                                if (!draining_reg)
                                begin
                                    draining_next = 1'b1;
                                    sd_next = 1'b1;
                                end
                            end
                        end
                    end
                    MODE_DRAIN:
                    begin
                        if (count_reg == '0)
                        begin
                            draining_next = 1'b0;
                        end
                        else
                        begin
                            ov_next = 1'b1;
                            oe_next = cells[0];
                            fbusy_next = 1'b1;
                            fkey_next = {cells[0].key_hi, cells[0].key_lo, cells[0].level};
                            pending_next = pending_reg - SUM_W'(cells[0].nbytes);
                            count_next = count_reg - CW'(1);
                            ctl.shift = 1'b1;
                        end
                    end
                    MODE_LOOKUP:
                    begin
                        if (found)
                        begin
                            if (found_e.preset >= rq_minp_reg)
                            begin
                                hit_next = 1'b1;
                                oe_next.handle = found_e.handle;
                                oe_next.preset = found_e.preset;
                            end
                        end
                        else if (fbusy_reg && fkey_reg ==
                                 {rq_reg.key_hi, rq_reg.key_lo, rq_reg.level})
                        begin
                            busy_next = 1'b1;
                        end
                    end
                    MODE_FLUSH:
                    begin
                        fbusy_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_TRIM:
            begin
                // Drop one head entry per cycle while over budget and above one entry
                if (pending_reg > SUM_W'(budget_reg) && count_reg > CW'(1))
                begin
                    ctl.shift = 1'b1;
                    count_next = count_reg - CW'(1);
                    ndrop_next = ndrop_reg + 5'd1;
                    drops_next = drops_reg + 32'd1;
                    dbytes_next = dbytes_reg + 48'(cells[0].nbytes);
                    pending_next = pending_reg - SUM_W'(cells[0].nbytes);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture the request and register the result fields
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rq_mode_reg <= mode;
            rq_reg <= '{key_hi, key_lo, level, entry_handle, preset, entry_bytes};
            rq_minp_reg <= min_quality;
        end
        sd_reg <= sd_next;
        hit_reg <= hit_next;
        busy_reg <= busy_next;
        ov_reg <= ov_next;
        oe_reg <= oe_next;
        ndrop_reg <= ndrop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            budget_reg <= BUDGET_RESET;
            enable_reg <= 1'b1;
            count_reg <= '0;
            pending_reg <= '0;
            draining_reg <= 1'b0;
            fbusy_reg <= 1'b0;
            fkey_reg <= '0;
            drops_reg <= '0;
            dbytes_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pending_reg <= pending_next;
            draining_reg <= draining_next;
            fbusy_reg <= fbusy_next;
            fkey_reg <= fkey_next;
            drops_reg <= drops_next;
            dbytes_reg <= dbytes_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_BYTES)
                begin
                    budget_reg <= cfg_data;
                end
                else
                begin
                    enable_reg <= cfg_data[0];
                end
            end
        end
    end

    // Drive the result; res_valid clears in IDLE once taken
    assign res_valid = res_valid_reg && (state_reg == ST_IDLE);
    assign start_drain = sd_reg;
    assign dropped_count = ndrop_reg;
    assign hit = hit_reg;
    assign busy_res = busy_reg;
    assign out_valid = ov_reg;
    assign out_key_hi = oe_reg.key_hi;
    assign out_key_lo = oe_reg.key_lo;
    assign out_level = oe_reg.level;
    assign out_handle = oe_reg.handle;
    assign out_preset = oe_reg.preset;
    assign out_bytes = oe_reg.nbytes;
    assign pending_total = (pending_reg > SUM_W'(M36)) ? M36 : pending_reg[35:0];

    // Queue occupancy never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");
    // At most one live cell matches a key
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(mvec))
        else $error("duplicate key in queue");
    // No request accepted while one is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("request taken while busy");

endmodule

@@ rtl/wcq_cell.sv @@
module wcq_cell
    import wcq_pkg::*;
(
    input  logic       clk,
    input  wcq_ctl_t   ctl,
    input  logic       load_here,
    input  logic       is_match_upd,
    input  wcq_entry_t new_entry,
    input  wcq_entry_t neighbor,
    input  logic [2:0] cmp_level,
    input  logic [63:0] cmp_hi,
    input  logic [63:0] cmp_lo,
    output wcq_entry_t entry,
    output logic       key_eq
);

    wcq_entry_t entry_reg;

    assign entry = entry_reg;
    assign key_eq = (entry_reg.key_hi == cmp_hi) && (entry_reg.key_lo == cmp_lo)
        && (entry_reg.level == cmp_level);

    // Hold, shift from the neighbor, load or update in place
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            entry_reg <= new_entry;
        end
        else if (ctl.update && is_match_upd)
        begin
            entry_reg.handle <= new_entry.handle;
            entry_reg.preset <= new_entry.preset;
            entry_reg.nbytes <= new_entry.nbytes;
        end
        else if (ctl.shift)
        begin
            entry_reg <= neighbor;
        end
    end

endmodule
